// ===== rtl/mudalu_pkg.sv =====
`timescale 1ns / 1ps
package mudalu_pkg;
   localparam int TickBitsDefault = 32;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_CMP = 3'd4,
      CMD_RAT = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] a_ticks;
      logic [31:0]        a_unit;
      logic signed [31:0] b_ticks;
      logic [31:0]        b_unit;
      logic [31:0]        scalar;
   } req_type;

   typedef struct packed {
      logic signed [63:0] res_ticks;
      logic [31:0]        res_unit;
      logic               less;
      logic               equal;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
      logic [63:0] remainder;
   } div_rsp_type;
endpackage

// ===== rtl/mudalu_div.sv =====
`timescale 1ns / 1ps
module mudalu_div
   import mudalu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   logic [63:0] quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, dsr_ff};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = 64'd0;
         dsr_in  = div_req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
         end
         quo_in = {quo_ff[62:0], ~trial[64]};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;
endmodule

// ===== rtl/mixed_unit_duration_alu.sv =====
`timescale 1ns / 1ps
// One item at a time; busy stays high from the accepting edge until the result strobe. Results
// appear on rsp_ for one cycle with rsp_valid and cannot be stalled. Every division runs on the
// shared 64-step restoring divider. Add and subtract run one division per Euclid step (at most 46
// for 32-bit units) plus two more to rescale; divide and ratio take one division; multiply passes
// through S_MA and S_FIN, and compare through S_MA, S_MB and S_FIN.
module mixed_unit_duration_alu
   import mudalu_pkg::*;
#(
   parameter int TICK_BITS = TickBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);
   typedef enum logic [3:0] {
      S_IDLE, S_GCD, S_GCDW, S_DA, S_DAW, S_DB, S_DBW, S_MA, S_MB, S_FIN, S_DIVW, S_SEC, S_SECW
   } state_type;

   state_type   state_ff;
   cmd_type     cmd_ff;
   logic signed [31:0] at_ff, bt_ff;
   logic [63:0] x_ff, y_ff, ga_ff, gb_ff, sa_ff, sb_ff;
   logic [31:0] au_ff, bu_ff, sc_ff;
   logic        neg_ff;
   logic        busy_ff, valid_ff;
   rsp_type     rsp_ff;
   div_req_type dreq;
   div_rsp_type drsp;
   logic signed [31:0] a_ext, b_ext;
   logic [63:0] q_signed, abs_a, abs_b;

   mudalu_div u_div (.clock(clock), .reset(reset), .div_req(dreq), .div_rsp(drsp));

   always_comb begin
      a_ext = 32'(signed'(req_item.a_ticks[TICK_BITS-1:0]));
      b_ext = 32'(signed'(req_item.b_ticks[TICK_BITS-1:0]));
      q_signed = neg_ff ? (64'd0 - drsp.quotient) : drsp.quotient;
      abs_a = sa_ff[63] ? (64'd0 - sa_ff) : sa_ff;
      abs_b = sb_ff[63] ? (64'd0 - sb_ff) : sb_ff;
   end

   always_ff @(posedge clock) begin
      dreq.start <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         dreq     <= '0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  busy_ff <= 1'b1;
                  cmd_ff  <= cmd_type'(req_item.cmd);
                  at_ff   <= a_ext;
                  bt_ff   <= b_ext;
                  au_ff   <= req_item.a_unit;
                  bu_ff   <= req_item.b_unit;
                  sc_ff   <= req_item.scalar;
                  x_ff    <= {32'd0, req_item.a_unit};
                  y_ff    <= {32'd0, req_item.b_unit};
                  rsp_ff  <= '0;
                  unique case (req_item.cmd) inside
                     CMD_ADD, CMD_SUB: state_ff <= S_GCD;
                     CMD_MUL: state_ff <= S_MA;
                     CMD_DIV: state_ff <= S_DA;
                     CMD_CMP, CMD_RAT: state_ff <= S_MA;
                     default: state_ff <= S_FIN;
                  endcase
               end
            end
            S_GCD: begin
               if (y_ff == 64'd0) begin
                  if (x_ff == 64'd0) begin
                     rsp_ff.status <= 1'b1;
                     state_ff <= S_FIN;
                  end else begin
                     rsp_ff.res_unit <= x_ff[31:0];
                     dreq.start    <= 1'b1;
                     dreq.dividend <= {32'd0, au_ff};
                     dreq.divisor  <= x_ff;
                     state_ff <= S_DAW;
                  end
               end else begin
                  dreq.start    <= 1'b1;
                  dreq.dividend <= x_ff;
                  dreq.divisor  <= y_ff;
                  state_ff <= S_GCDW;
               end
            end
            S_GCDW: begin
               if (drsp.done) begin
                  x_ff <= y_ff;
                  y_ff <= drsp.remainder;
                  state_ff <= S_GCD;
               end
            end
            S_DAW: begin
               if (drsp.done) begin
                  ga_ff <= drsp.quotient;
                  dreq.start    <= 1'b1;
                  dreq.dividend <= {32'd0, bu_ff};
                  dreq.divisor  <= x_ff;
                  state_ff <= S_DBW;
               end
            end
            S_DBW: begin
               if (drsp.done) begin
                  gb_ff <= drsp.quotient;
                  state_ff <= S_DB;
               end
            end
            S_DB: begin
               sa_ff <= at_ff * signed'({1'b0, ga_ff[31:0]});
               sb_ff <= bt_ff * signed'({1'b0, gb_ff[31:0]});
               state_ff <= S_SEC;
            end
            S_SEC: begin
               rsp_ff.res_ticks <= (cmd_ff == CMD_ADD) ? sa_ff + sb_ff : sa_ff - sb_ff;
               state_ff <= S_FIN;
            end
            S_DA: begin
               rsp_ff.res_unit <= au_ff;
               if (sc_ff == 32'd0) begin
                  rsp_ff.status <= 1'b1;
                  state_ff <= S_FIN;
               end else begin
                  neg_ff        <= at_ff[31];
                  dreq.start    <= 1'b1;
                  dreq.dividend <= at_ff[31] ? 64'd0 - 64'(at_ff) : 64'(at_ff);
                  dreq.divisor  <= {32'd0, sc_ff};
                  state_ff <= S_DIVW;
               end
            end
            S_DIVW: begin
               if (drsp.done) begin
                  rsp_ff.res_ticks <= q_signed;
                  state_ff <= S_FIN;
               end
            end
            S_MA: begin
               if (cmd_ff == CMD_MUL) begin
                  rsp_ff.res_ticks <= at_ff * signed'({1'b0, sc_ff});
                  rsp_ff.res_unit  <= au_ff;
                  state_ff <= S_FIN;
               end else begin
                  sa_ff <= at_ff * signed'({1'b0, au_ff});
                  sb_ff <= bt_ff * signed'({1'b0, bu_ff});
                  rsp_ff.res_unit <= 32'd1;
                  state_ff <= S_MB;
               end
            end
            S_MB: begin
               if (cmd_ff == CMD_CMP) begin
                  rsp_ff.less  <= signed'(sa_ff) < signed'(sb_ff);
                  rsp_ff.equal <= sa_ff == sb_ff;
                  state_ff <= S_FIN;
               end else if (sb_ff == 64'd0) begin
                  rsp_ff.status <= 1'b1;
                  state_ff <= S_FIN;
               end else begin
                  neg_ff        <= sa_ff[63] ^ sb_ff[63];
                  dreq.start    <= 1'b1;
                  dreq.dividend <= abs_a;
                  dreq.divisor  <= abs_b;
                  state_ff <= S_SECW;
               end
            end
            S_SECW: begin
               if (drsp.done) begin
                  rsp_ff.res_ticks <= q_signed;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               valid_ff <= 1'b1;
               busy_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

// ===== dv/duration_checker.sv =====
`timescale 1ns / 1ps
module duration_checker
   import mudalu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      mismatches,
   output int      pending,
   output int      checked
);
   rsp_type expected_results[$];

   function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic rsp_type predict_result(req_type q);
      rsp_type r;
      logic signed [63:0] at, bt, au, bu, sc, sa, sb;
      logic [63:0] g;
      r = '0;
      at = q.a_ticks;
      bt = q.b_ticks;
      au = {32'b0, q.a_unit};
      bu = {32'b0, q.b_unit};
      sc = {32'b0, q.scalar};
      sa = at * au;
      sb = bt * bu;
      case (q.cmd) inside
         CMD_ADD, CMD_SUB: begin
            g = euclid_gcd(au, bu);
            if (g == 0) begin
               r.status = 1'b1;
            end else begin
               if (q.cmd == CMD_ADD) begin
                  r.res_ticks = at * (au / g) + bt * (bu / g);
               end else begin
                  r.res_ticks = at * (au / g) - bt * (bu / g);
               end
               r.res_unit = g[31:0];
            end
         end
         CMD_MUL: begin
            r.res_ticks = at * sc;
            r.res_unit = q.a_unit;
         end
         CMD_DIV: begin
            r.res_unit = q.a_unit;
            if (q.scalar == 0) begin
               r.status = 1'b1;
            end else begin
               r.res_ticks = at / sc;
            end
         end
         CMD_CMP: begin
            r.less = sa < sb;
            r.equal = sa == sb;
            r.res_unit = 1;
         end
         CMD_RAT: begin
            r.res_unit = 1;
            if (sb == 0) begin
               r.status = 1'b1;
            end else begin
               r.res_ticks = sa / sb;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      rsp_type e;
      int errs;
      errs = 0;
      if (reset) begin
         mismatches <= 0;
         checked <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("Result arrived with no item outstanding.");
               errs++;
            end else begin
               e = expected_results.pop_front();
               checked <= checked + 1;
               if (rsp_item.res_ticks !== e.res_ticks) begin
                  $error("res_ticks expected %0d actual %0d", e.res_ticks, rsp_item.res_ticks);
                  errs++;
               end
               if (rsp_item.res_unit !== e.res_unit) begin
                  $error("res_unit expected %0d actual %0d", e.res_unit, rsp_item.res_unit);
                  errs++;
               end
               if (rsp_item.less !== e.less) begin
                  $error("less expected %0b actual %0b", e.less, rsp_item.less);
                  errs++;
               end
               if (rsp_item.equal !== e.equal) begin
                  $error("equal expected %0b actual %0b", e.equal, rsp_item.equal);
                  errs++;
               end
               if (rsp_item.status !== e.status) begin
                  $error("status expected %0b actual %0b", e.status, rsp_item.status);
                  errs++;
               end
            end
         end
         mismatches <= mismatches + errs;
         if (start && !busy) begin
            expected_results.push_back(predict_result(req_item));
         end
      end
   end
endmodule

// ===== dv/mixed_unit_duration_alu_test.sv =====
`timescale 1ns / 1ps
module mixed_unit_duration_alu_test;
   import mudalu_pkg::*;

   localparam int StallLimit = 20000;
   localparam int RandomItems = 1130;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      mismatches, pending, checked;
   int      sent = 0;
   int      idle_pct = 0;
   int      quiet = 0;

   always #10 clock = ~clock;

   mixed_unit_duration_alu DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   duration_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .mismatches(mismatches), .pending(pending), .checked(checked)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= StallLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return $urandom_range(0, 3);
         4: return $urandom_range(0, 1000);
         5: return -$urandom_range(0, 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_unit();
      logic [31:0] u;
      u = pick_word();
      return (u == 0) ? 32'd1 : u;
   endfunction

   task automatic send_item(req_type q);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= q;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      sent++;
   endtask

   task automatic send_fields(cmd_type c, logic [31:0] at, logic [31:0] au, logic [31:0] bt,
                              logic [31:0] bu, logic [31:0] sc);
      req_type q;
      q.cmd = c;
      q.a_ticks = at;
      q.a_unit = au;
      q.b_ticks = bt;
      q.b_unit = bu;
      q.scalar = sc;
      send_item(q);
   endtask

   initial begin
      req_type q;
      logic [31:0] f0, f1, f2;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_fields(CMD_ADD, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_fffe, 0);
      send_fields(CMD_SUB, 32'h8000_0000, 60, 32'h7fff_ffff, 24, 0);
      send_fields(CMD_ADD, 5, 0, 7, 0, 0);
      send_fields(CMD_SUB, 5, 0, -7, 3600, 0);
      send_fields(CMD_ADD, -3, 1836311903, 9, 1134903170, 0);
      send_fields(CMD_MUL, 32'h8000_0000, 1, 0, 1, 32'hffff_ffff);
      send_fields(CMD_MUL, 32'h7fff_ffff, 32'hffff_ffff, 0, 1, 32'hffff_ffff);
      send_fields(CMD_DIV, -7, 60, 0, 1, 0);
      send_fields(CMD_DIV, -7, 60, 0, 1, 2);
      send_fields(CMD_DIV, 32'h8000_0000, 24, 0, 1, 32'hffff_ffff);
      send_fields(CMD_DIV, 32'h8000_0000, 24, 0, 1, 1);
      send_fields(CMD_CMP, 1, 60, 60, 1, 0);
      send_fields(CMD_CMP, -1, 24, 1, 24, 0);
      send_fields(CMD_CMP, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 0);
      send_fields(CMD_RAT, 100, 60, 0, 24, 0);
      send_fields(CMD_RAT, -100, 60, 7, 24, 0);
      send_fields(CMD_RAT, 32'h8000_0000, 32'hffff_ffff, 1, 1, 0);
      send_fields(CMD_RAT, 32'h7fff_ffff, 32'hffff_ffff, -1, 1, 0);
      q = '0; q.cmd = 3'd6; q.a_ticks = 5; q.a_unit = 5; send_item(q);
      q = '1; q.cmd = 3'd7; send_item(q);

      for (int i = 0; i < RandomItems; i++) begin
         idle_pct = (i < RandomItems / 3) ? 20 : (i < 2 * RandomItems / 3) ? 73 : 0;
         if ($urandom_range(0, 9) == 0) idle_pct = 0;
         q.cmd = ($urandom_range(0, 99) < 2) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
         q.a_ticks = pick_word();
         q.b_ticks = pick_word();
         q.a_unit = pick_unit();
         q.b_unit = pick_unit();
         q.scalar = pick_word();
         if ($urandom_range(0, 9) == 0) begin
            // Consecutive Fibonacci units drive long Euclid chains.
            f0 = 1; f1 = 1;
            repeat ($urandom_range(5, 45)) begin
               f2 = f0 + f1; f0 = f1; f1 = f2;
            end
            q.a_unit = f1;
            q.b_unit = f0;
         end else if ($urandom_range(0, 9) == 0) begin
            q.b_ticks = 0;
         end
         send_item(q);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d items over all six operations and the unused codes, %0d results checked.",
               sent, checked);
      $display("Gaps at 20 and 73 percent and back-to-back traffic were exercised.");
      if (mismatches == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
